### rtl/ssag_pkg.sv
// shared types and constants for the spiral scan address generator
// no dependencies; used by every module of the block by scoped name
package ssag_pkg;

	// default grid limit
	localparam int DEF_MAX_DIM = 64;

	// visit number modulo 16
	localparam int DIGIT_W = 4;

	// configuration port
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS   = 2'd0,
		REG_COLS   = 2'd1,
		REG_CORNER = 2'd2,
		REG_CW     = 2'd3
	} reg_idx_t;

	// register reset values
	localparam int RST_DIM    = 4;
	localparam int RST_CORNER = 0;
	localparam logic RST_CW   = 1'b1;

	// start corner codes
	localparam logic [1:0] CORNER_TL = 2'd0;
	localparam logic [1:0] CORNER_TR = 2'd1;
	localparam logic [1:0] CORNER_BR = 2'd2;
	localparam logic [1:0] CORNER_BL = 2'd3;

	// control from the request stage to the walker
	typedef struct packed {
		logic fire;
		logic restart;
	} step_req_t;

endpackage

### rtl/spiral_scan_address_generator.sv
// Spiral scan address generator: walks a rows-by-cols grid in spiral order.
// Each request on the input channel (in_valid/in_ready, field restart) yields
// exactly one result on the output channel (out_valid/out_ready). restart=1
// begins a new walk at the configured corner and gives its first cell;
// restart=0 gives the next cell. Results carry cell_row, cell_col, digit
// (visit number mod 16), cell_valid and last_cell; once the walk is done,
// results come back with every field zero.
// Configuration (rows, cols, start_corner, clockwise) is to be written by the user
// through cfg_wr_en/cfg_addr/cfg_wdata only while the block is idle; the block
// itself does not enforce this. It is sampled only when a restart request is processed.
// Timing: a request goes into a one-entry request register; the walker steps
// when the output register is free or being emptied, and loads the output
// register. One request per cycle is sustained while out_ready is high;
// the only loop is the registered walker state update.
// When the receiver stalls, the output register holds and one more request
// is still taken into the request register; after that in_ready drops.
// Reset clears both stages and leaves the walk finished, with registers at
// rows=4, cols=4, top-left corner, clockwise.
// depends on ssag_pkg, ssag_cfg_regs, ssag_walker
module spiral_scan_address_generator #(
	parameter int MAX_DIM = ssag_pkg::DEF_MAX_DIM,
	parameter int DIM_W   = $clog2(MAX_DIM),
	parameter int CFG_W   = $clog2(MAX_DIM + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ssag_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]               cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [DIM_W-1:0]               cell_row,
	output logic [DIM_W-1:0]               cell_col,
	output logic [ssag_pkg::DIGIT_W-1:0]   digit,
	output logic                           cell_valid,
	output logic                           last_cell
);

	logic [CFG_W-1:0] rows, cols;
	logic [1:0]       start_corner;
	logic             clockwise;

	logic valid_s1;
	logic restart_s1;
	logic out_valid_q;
	logic advance;

	ssag_pkg::step_req_t req;

	logic [DIM_W-1:0]             res_row, res_col;
	logic [ssag_pkg::DIGIT_W-1:0] res_digit;
	logic                         res_valid, res_last;

	logic [DIM_W-1:0]             row_q, col_q;
	logic [ssag_pkg::DIGIT_W-1:0] digit_q;
	logic                         cvalid_q, last_q;

	ssag_cfg_regs #(
		.MAX_DIM(MAX_DIM),
		.CFG_W  (CFG_W)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.rows        (rows),
		.cols        (cols),
		.start_corner(start_corner),
		.clockwise   (clockwise)
	);

	// output register free or being emptied this cycle
	assign advance     = !out_valid_q || out_ready;
	assign in_ready    = !valid_s1 || advance;
	assign req.fire    = valid_s1 && advance;
	assign req.restart = restart_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			restart_s1 <= restart;
		end
	end

	ssag_walker #(
		.MAX_DIM(MAX_DIM),
		.DIM_W  (DIM_W),
		.CFG_W  (CFG_W)
	) u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rows        (rows),
		.cols        (cols),
		.start_corner(start_corner),
		.clockwise   (clockwise),
		.res_row     (res_row),
		.res_col     (res_col),
		.res_digit   (res_digit),
		.res_valid   (res_valid),
		.res_last    (res_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.fire) begin
			row_q    <= res_row;
			col_q    <= res_col;
			digit_q  <= res_digit;
			cvalid_q <= res_valid;
			last_q   <= res_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_row   = row_q;
	assign cell_col   = col_q;
	assign digit      = digit_q;
	assign cell_valid = cvalid_q;
	assign last_cell  = last_q;

endmodule

### rtl/ssag_cfg_regs.sv
// configuration registers of the spiral scan address generator
// depends on ssag_pkg
module ssag_cfg_regs #(
	parameter int MAX_DIM = ssag_pkg::DEF_MAX_DIM,
	parameter int CFG_W   = $clog2(MAX_DIM + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ssag_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]               cfg_wdata,
	output logic [CFG_W-1:0]               rows,
	output logic [CFG_W-1:0]               cols,
	output logic [1:0]                     start_corner,
	output logic                           clockwise
);

	localparam int RST_DIM_C = (ssag_pkg::RST_DIM > MAX_DIM) ? MAX_DIM : ssag_pkg::RST_DIM;

	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] cols_q;
	logic [1:0]       corner_q;
	logic             cw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= CFG_W'(RST_DIM_C);
			cols_q   <= CFG_W'(RST_DIM_C);
			corner_q <= 2'(ssag_pkg::RST_CORNER);
			cw_q     <= ssag_pkg::RST_CW;
		end else if (cfg_wr_en) begin
			case (ssag_pkg::reg_idx_t'(cfg_addr))
				ssag_pkg::REG_ROWS:   rows_q   <= cfg_wdata;
				ssag_pkg::REG_COLS:   cols_q   <= cfg_wdata;
				ssag_pkg::REG_CORNER: corner_q <= cfg_wdata[1:0];
				ssag_pkg::REG_CW:     cw_q     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign rows         = rows_q;
	assign cols         = cols_q;
	assign start_corner = corner_q;
	assign clockwise    = cw_q;

endmodule

### rtl/ssag_walker.sv
// spiral walk state and the one-cell step logic
// depends on ssag_pkg; fed by the request stage and the configuration registers
module ssag_walker #(
	parameter int MAX_DIM = ssag_pkg::DEF_MAX_DIM,
	parameter int DIM_W   = $clog2(MAX_DIM),
	parameter int CFG_W   = $clog2(MAX_DIM + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ssag_pkg::step_req_t          req,
	input  logic [CFG_W-1:0]             rows,
	input  logic [CFG_W-1:0]             cols,
	input  logic [1:0]                   start_corner,
	input  logic                         clockwise,
	output logic [DIM_W-1:0]             res_row,
	output logic [DIM_W-1:0]             res_col,
	output logic [ssag_pkg::DIGIT_W-1:0] res_digit,
	output logic                         res_valid,
	output logic                         res_last
);

	localparam int REM_W = $clog2(MAX_DIM * MAX_DIM + 1);

	typedef enum logic [1:0] {
		HEAD_RIGHT = 2'd0,
		HEAD_DOWN  = 2'd1,
		HEAD_LEFT  = 2'd2,
		HEAD_UP    = 2'd3
	} heading_t;

	logic [DIM_W-1:0]             row_q, col_q;
	logic [DIM_W-1:0]             top_q, bottom_q, left_q, right_q;
	heading_t                     head_q;
	logic [REM_W-1:0]             rem_q;
	logic [ssag_pkg::DIGIT_W-1:0] digit_q;
	logic                         spin_q;

	logic [DIM_W-1:0]             e_row, e_col, e_top, e_bottom, e_left, e_right;
	heading_t                     e_head;
	logic [REM_W-1:0]             e_rem;
	logic [ssag_pkg::DIGIT_W-1:0] e_digit;
	logic                         e_spin;

	logic [DIM_W-1:0]             n_row, n_col, n_top, n_bottom, n_left, n_right;
	heading_t                     n_head;
	logic [REM_W-1:0]             n_rem;
	logic [ssag_pkg::DIGIT_W-1:0] n_digit;

	logic [CFG_W-1:0]   r_cl, c_cl;
	logic [2*CFG_W-1:0] area;
	logic               room1;
	logic               close_top, close_bottom, close_right;

	function automatic logic room(heading_t h, logic [DIM_W-1:0] row, logic [DIM_W-1:0] col,
			logic [DIM_W-1:0] top, logic [DIM_W-1:0] bottom,
			logic [DIM_W-1:0] left, logic [DIM_W-1:0] right);
		logic ok;
		case (h)
			HEAD_RIGHT: ok = col < right;
			HEAD_DOWN:  ok = row < bottom;
			HEAD_LEFT:  ok = col > left;
			HEAD_UP:    ok = row > top;
			default:    ok = 1'b0;
		endcase
		return ok;
	endfunction

	// clamp sizes to 1..MAX_DIM
	always_comb begin
		if (rows == '0) begin
			r_cl = CFG_W'(1);
		end else if (rows > CFG_W'(MAX_DIM)) begin
			r_cl = CFG_W'(MAX_DIM);
		end else begin
			r_cl = rows;
		end
		if (cols == '0) begin
			c_cl = CFG_W'(1);
		end else if (cols > CFG_W'(MAX_DIM)) begin
			c_cl = CFG_W'(MAX_DIM);
		end else begin
			c_cl = cols;
		end
	end

	assign area = r_cl * c_cl;

	always_comb begin
		// state seen by this request: fresh walk on restart
		if (req.restart) begin
			e_spin   = clockwise;
			e_top    = '0;
			e_left   = '0;
			e_bottom = DIM_W'(r_cl - CFG_W'(1));
			e_right  = DIM_W'(c_cl - CFG_W'(1));
			e_row    = (start_corner == ssag_pkg::CORNER_BR || start_corner == ssag_pkg::CORNER_BL)
				? DIM_W'(r_cl - CFG_W'(1)) : '0;
			e_col    = (start_corner == ssag_pkg::CORNER_TR || start_corner == ssag_pkg::CORNER_BR)
				? DIM_W'(c_cl - CFG_W'(1)) : '0;
			e_head   = clockwise ? heading_t'(start_corner) : heading_t'(start_corner + 2'd1);
			e_rem    = area[REM_W-1:0];
			e_digit  = '0;
		end else begin
			e_spin   = spin_q;
			e_top    = top_q;
			e_left   = left_q;
			e_bottom = bottom_q;
			e_right  = right_q;
			e_row    = row_q;
			e_col    = col_q;
			e_head   = head_q;
			e_rem    = rem_q;
			e_digit  = digit_q;
		end

		n_row    = e_row;
		n_col    = e_col;
		n_top    = e_top;
		n_bottom = e_bottom;
		n_left   = e_left;
		n_right  = e_right;
		n_head   = e_head;
		n_rem    = e_rem;
		n_digit  = e_digit;

		res_valid = e_rem != '0;
		res_last  = e_rem == REM_W'(1);
		res_row   = res_valid ? e_row : '0;
		res_col   = res_valid ? e_col : '0;
		res_digit = res_valid ? e_digit : '0;

		room1        = room(e_head, e_row, e_col, e_top, e_bottom, e_left, e_right);
		close_top    = (e_head == HEAD_RIGHT && e_spin) || (e_head == HEAD_LEFT && !e_spin);
		close_bottom = (e_head == HEAD_LEFT && e_spin) || (e_head == HEAD_RIGHT && !e_spin);
		close_right  = (e_head == HEAD_DOWN && e_spin) || (e_head == HEAD_UP && !e_spin);

		if (res_valid) begin
			n_rem   = e_rem - REM_W'(1);
			n_digit = e_digit + ssag_pkg::DIGIT_W'(1);
			if (n_rem != '0) begin
				// line finished: pull in its bound and turn
				if (!room1) begin
					if (close_top) begin
						n_top = e_top + DIM_W'(1);
					end else if (close_bottom) begin
						if (e_bottom != '0) n_bottom = e_bottom - DIM_W'(1);
					end else if (close_right) begin
						if (e_right != '0) n_right = e_right - DIM_W'(1);
					end else begin
						n_left = e_left + DIM_W'(1);
					end
					n_head = e_spin ? heading_t'(e_head + 2'd1) : heading_t'(e_head + 2'd3);
				end
				if (room(n_head, e_row, e_col, n_top, n_bottom, n_left, n_right)) begin
					case (n_head)
						HEAD_RIGHT: n_col = e_col + DIM_W'(1);
						HEAD_DOWN:  n_row = e_row + DIM_W'(1);
						HEAD_LEFT:  n_col = e_col - DIM_W'(1);
						HEAD_UP:    n_row = e_row - DIM_W'(1);
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			top_q    <= '0;
			bottom_q <= '0;
			left_q   <= '0;
			right_q  <= '0;
			head_q   <= HEAD_RIGHT;
			rem_q    <= '0;
			digit_q  <= '0;
			spin_q   <= 1'b1;
		end else if (req.fire) begin
			row_q    <= n_row;
			col_q    <= n_col;
			top_q    <= n_top;
			bottom_q <= n_bottom;
			left_q   <= n_left;
			right_q  <= n_right;
			head_q   <= n_head;
			rem_q    <= n_rem;
			digit_q  <= n_digit;
			spin_q   <= e_spin;
		end
	end

endmodule
